### hw/rtl/gtsm_pkg.sv
// ----------------------------------------------------------------------------
// gtsm_pkg
// Types and constants shared by the guarded transition state machine.
// ----------------------------------------------------------------------------
package gtsm_pkg;

  localparam int unsigned NumStates  = 16;
  localparam int unsigned NumTrans   = 32;
  localparam int unsigned NumConds   = 4;
  localparam int unsigned NumParams  = 16;
  localparam int unsigned WalkLen    = 2 * NumTrans;
  localparam int unsigned WalkW      = $clog2(WalkLen);
  localparam int unsigned TransW     = $clog2(NumTrans);
  localparam logic [4:0]  AnyState   = 5'd16;

  typedef enum logic [3:0] {
    CMD_SET_PARAM   = 4'd0,
    CMD_TRIGGER     = 4'd1,
    CMD_ANIM_END    = 4'd2,
    CMD_UPDATE      = 4'd3,
    CMD_WRITE_STATE = 4'd4,
    CMD_WRITE_TRANS = 4'd5,
    CMD_WRITE_COND  = 4'd6,
    CMD_SET_ENTRY   = 4'd7,
    CMD_INIT        = 4'd8,
    CMD_REMOVE      = 4'd9,
    CMD_CLEAR_ALL   = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    COND_EQ    = 3'd0,
    COND_GT    = 3'd1,
    COND_LT    = 3'd2,
    COND_TRIG  = 3'd3,
    COND_ENDED = 3'd4
  } cond_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK
  } ctrl_state_e;

  typedef struct packed {
    logic [3:0]         command;
    logic [4:0]         index;
    logic [1:0]         cond_slot;
    logic [4:0]         from_state;
    logic [3:0]         to_state;
    logic [2:0]         cond_count;
    logic [2:0]         cond_type;
    logic [3:0]         param_index;
    logic signed [31:0] value;
    logic               enable;
  } in_item_t;

  typedef struct packed {
    logic [3:0] current_state;
    logic       current_valid;
    logic       started;
    logic [3:0] entry_state;
    logic       entry_valid;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         param;
    logic signed [31:0] value;
  } cond_t;

  typedef struct packed {
    logic             exec;
    logic             rd_en;
    logic [WalkW-1:0] rd_addr;
    logic             take;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic hit;
    logic last;
  } dp_status_t;

endpackage

### hw/rtl/gtsm_in_if.sv
// ----------------------------------------------------------------------------
// gtsm_in_if
// Valid/ready channel carrying command beats into the state machine.
// ----------------------------------------------------------------------------
interface gtsm_in_if
  import gtsm_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/gtsm_out_if.sv
// ----------------------------------------------------------------------------
// gtsm_out_if
// Valid/ready channel carrying result beats out of the state machine.
// ----------------------------------------------------------------------------
interface gtsm_out_if
  import gtsm_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/gtsm_dp.sv
// ----------------------------------------------------------------------------
// gtsm_dp
// Datapath: state store, transition table, condition memory, guard
// evaluation of one table row per cycle and the result register.
// ----------------------------------------------------------------------------
module gtsm_dp
  import gtsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   item_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output out_item_t  result_o
);

  logic signed [31:0] param_value_q [NumParams];
  logic [NumParams-1:0] param_known_q, param_known_d;
  logic [NumParams-1:0] trig_q, trig_d;
  logic                 anim_q, anim_d;
  logic [3:0]           cur_q, cur_d;
  logic                 cur_vld_q, cur_vld_d;
  logic [3:0]           entry_q, entry_d;
  logic                 entry_vld_q, entry_vld_d;
  logic [NumStates-1:0] present_q, present_d;
  logic [NumTrans-1:0]  tvalid_q, tvalid_d;
  logic [4:0]           tfrom_q [NumTrans];
  logic [3:0]           tto_q   [NumTrans];
  logic [2:0]           tcnt_q  [NumTrans];
  logic                 started;
  out_item_t            result_q;

  // condition memory, one bank per slot
  cond_t cmem [NumConds][NumTrans];
  cond_t row_q [NumConds];

  // walk stage registers
  logic             stg_vld_q;
  logic             stg_pass_q;
  logic             stg_last_q;
  logic             stg_tv_q;
  logic [4:0]       stg_from_q;
  logic [3:0]       stg_to_q;
  logic [2:0]       stg_cnt_q;

  logic [TransW-1:0] rd_t;
  logic [TransW-1:0] wr_t;
  logic [3:0]        sidx;
  logic              cand;
  logic              holds;
  logic [NumConds-1:0] cond_ok;
  logic [NumConds-1:0] cond_en;

  assign rd_t = cmd_i.rd_addr[TransW-1:0];
  assign wr_t = item_i.index[TransW-1:0];
  assign sidx = item_i.index[3:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && item_i.command == CMD_WRITE_COND) begin
      cmem[item_i.cond_slot][wr_t] <= '{kind:  item_i.cond_type,
                                        param: item_i.param_index,
                                        value: item_i.value};
    end
    if (cmd_i.rd_en) begin
      for (int k = 0; k < NumConds; k++) begin
        row_q[k] <= cmem[k][rd_t];
      end
      stg_pass_q <= cmd_i.rd_addr[WalkW-1];
      stg_last_q <= &cmd_i.rd_addr;
      stg_tv_q   <= tvalid_q[rd_t];
      stg_from_q <= tfrom_q[rd_t];
      stg_to_q   <= tto_q[rd_t];
      stg_cnt_q  <= tcnt_q[rd_t];
    end
    if (cmd_i.exec && item_i.command == CMD_WRITE_TRANS && item_i.enable) begin
      tfrom_q[wr_t] <= item_i.from_state;
      tto_q[wr_t]   <= item_i.to_state;
      tcnt_q[wr_t]  <= item_i.cond_count;
    end
    if (cmd_i.exec && item_i.command == CMD_SET_PARAM && !item_i.index[4]) begin
      param_value_q[sidx] <= item_i.value;
    end
    if (cmd_i.exec || cmd_i.take) begin
      result_q <= '{current_state: cur_vld_d ? cur_d : 4'd0,
                    current_valid: cur_vld_d,
                    started:       started,
                    entry_state:   entry_vld_d ? entry_d : 4'd0,
                    entry_valid:   entry_vld_d};
    end
  end

  // guard evaluation of the staged row
  always_comb begin
    for (int k = 0; k < NumConds; k++) begin
      cond_en[k] = (32'(k) < 32'(stg_cnt_q));
      unique case (row_q[k].kind)
        COND_ENDED: cond_ok[k] = anim_q;
        COND_TRIG:  cond_ok[k] = trig_q[row_q[k].param];
        COND_EQ:    cond_ok[k] = param_known_q[row_q[k].param] &&
                                 (param_value_q[row_q[k].param] == row_q[k].value);
        COND_GT:    cond_ok[k] = param_known_q[row_q[k].param] &&
                                 (param_value_q[row_q[k].param] > row_q[k].value);
        COND_LT:    cond_ok[k] = param_known_q[row_q[k].param] &&
                                 (param_value_q[row_q[k].param] < row_q[k].value);
        default:    cond_ok[k] = 1'b0;
      endcase
    end
    holds = &(cond_ok | ~cond_en);
    if (!stg_pass_q) begin
      cand = stg_tv_q && (stg_from_q == {1'b0, cur_q});
    end else begin
      cand = stg_tv_q && (stg_from_q == AnyState) && (stg_to_q != cur_q);
    end
  end

  assign status_o.cur_valid = cur_vld_q;
  assign status_o.hit       = stg_vld_q && cand && holds;
  assign status_o.last      = stg_vld_q && stg_last_q;
  assign result_o           = result_q;

  always_comb begin
    param_known_d = param_known_q;
    trig_d        = trig_q;
    anim_d        = anim_q;
    cur_d         = cur_q;
    cur_vld_d     = cur_vld_q;
    entry_d       = entry_q;
    entry_vld_d   = entry_vld_q;
    present_d     = present_q;
    tvalid_d      = tvalid_q;
    started       = 1'b0;

    if (cmd_i.take) begin
      if (status_o.hit && present_q[stg_to_q]) begin
        cur_d   = stg_to_q;
        started = 1'b1;
      end
      anim_d = 1'b0;
      trig_d = '0;
    end else if (cmd_i.exec) begin
      unique case (item_i.command)
        CMD_SET_PARAM: begin
          if (!item_i.index[4]) param_known_d[sidx] = 1'b1;
        end
        CMD_TRIGGER: begin
          if (!item_i.index[4]) trig_d[sidx] = 1'b1;
        end
        CMD_ANIM_END: anim_d = 1'b1;
        CMD_WRITE_STATE: begin
          if (!item_i.index[4]) begin
            if (!item_i.enable) begin
              if (present_q[sidx]) begin
                for (int t = 0; t < NumTrans; t++) begin
                  if (tfrom_q[t] == {1'b0, sidx} || tto_q[t] == sidx) tvalid_d[t] = 1'b0;
                end
                present_d[sidx] = 1'b0;
                if (cur_vld_q && cur_q == sidx) begin
                  cur_d     = entry_vld_q ? entry_q : 4'd0;
                  cur_vld_d = entry_vld_q;
                end
                if (entry_vld_q && entry_q == sidx) begin
                  entry_d     = 4'd0;
                  entry_vld_d = 1'b0;
                end
              end
            end else if (!present_q[sidx]) begin
              present_d[sidx] = 1'b1;
              if (present_q == '0) begin
                entry_d     = sidx;
                entry_vld_d = 1'b1;
                if (!cur_vld_q) begin
                  cur_d     = sidx;
                  cur_vld_d = 1'b1;
                  anim_d    = 1'b0;
                  started   = 1'b1;
                end
              end
            end
          end
        end
        CMD_WRITE_TRANS: tvalid_d[wr_t] = item_i.enable;
        CMD_SET_ENTRY: begin
          if (present_q[item_i.to_state]) begin
            entry_d     = item_i.to_state;
            entry_vld_d = 1'b1;
            if (!cur_vld_q) begin
              cur_d     = item_i.to_state;
              cur_vld_d = 1'b1;
              anim_d    = 1'b0;
              started   = 1'b1;
            end
          end
        end
        CMD_INIT: begin
          if (entry_vld_q && present_q[entry_q]) begin
            cur_d     = entry_q;
            cur_vld_d = 1'b1;
            anim_d    = 1'b0;
            started   = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (!item_i.index[4] && present_q[sidx]) begin
            for (int t = 0; t < NumTrans; t++) begin
              if (tfrom_q[t] == {1'b0, sidx} || tto_q[t] == sidx) tvalid_d[t] = 1'b0;
            end
            present_d[sidx] = 1'b0;
            if (cur_vld_q && cur_q == sidx) begin
              cur_d     = entry_vld_q ? entry_q : 4'd0;
              cur_vld_d = entry_vld_q;
            end
            if (entry_vld_q && entry_q == sidx) begin
              entry_d     = 4'd0;
              entry_vld_d = 1'b0;
            end
          end
        end
        CMD_CLEAR_ALL: begin
          param_known_d = '0;
          trig_d        = '0;
          anim_d        = 1'b0;
          cur_d         = 4'd0;
          cur_vld_d     = 1'b0;
          entry_d       = 4'd0;
          entry_vld_d   = 1'b0;
          present_d     = '0;
          tvalid_d      = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      param_known_q <= '0;
      trig_q        <= '0;
      anim_q        <= 1'b0;
      cur_q         <= 4'd0;
      cur_vld_q     <= 1'b0;
      entry_q       <= 4'd0;
      entry_vld_q   <= 1'b0;
      present_q     <= '0;
      tvalid_q      <= '0;
      stg_vld_q     <= 1'b0;
    end else begin
      param_known_q <= param_known_d;
      trig_q        <= trig_d;
      anim_q        <= anim_d;
      cur_q         <= cur_d;
      cur_vld_q     <= cur_vld_d;
      entry_q       <= entry_d;
      entry_vld_q   <= entry_vld_d;
      present_q     <= present_d;
      tvalid_q      <= tvalid_d;
      stg_vld_q     <= cmd_i.rd_en;
    end
  end

endmodule

### hw/rtl/gtsm_ctrl.sv
// ----------------------------------------------------------------------------
// gtsm_ctrl
// Controller: input handshake, table walk sequencing and output valid.
// ----------------------------------------------------------------------------
module gtsm_ctrl
  import gtsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [3:0] in_command_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e    st_q, st_d;
  logic [WalkW:0] cnt_q, cnt_d;
  logic           out_vld_q, out_vld_d;
  logic           accept;
  logic           finish;

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    finish     = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        in_ready_o = !out_vld_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          if (in_command_i == CMD_UPDATE && status_i.cur_valid) begin
            st_d  = ST_WALK;
            cnt_d = '0;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      ST_WALK: begin
        finish        = status_i.hit || status_i.last;
        cmd_o.take    = finish;
        cmd_o.rd_en   = !finish && !cnt_q[WalkW];
        cmd_o.rd_addr = cnt_q[WalkW-1:0];
        if (cmd_o.rd_en) cnt_d = cnt_q + 1'b1;
        if (finish) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.exec || cmd_o.take) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_hit_only_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.hit |-> st_q == ST_WALK) else $error("guard hit outside walk");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_WALK |-> cnt_q <= (WalkW+1)'(WalkLen)) else $error("walk counter overrun");

  a_walk_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WALK && !status_i.hit && !status_i.last) |=> st_q == ST_WALK)
    else $error("walk ended early");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WALK && finish) |=> out_vld_q) else $error("walk lost its result");

endmodule

### hw/rtl/guarded_transition_state_machine.sv
// ----------------------------------------------------------------------------
// guarded_transition_state_machine
// Programmable state machine with a prioritized guarded transition table.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command beat (parameter, trigger, table writes, update,
//   entry, remove, clear). out_o returns exactly one result beat per command:
//   current state, entry state and a started pulse.
//   Non-update commands and updates with no current state have their result
//   valid in the cycle after the accepting edge. An update walks the table
//   one row per cycle, first the rows leaving the current state and then the
//   any-state rows, with all four guards of a row checked at once; the
//   condition memory read is registered, and the walk ends at the first row
//   that passes or after the last of its 64 row reads.
//   One command is in flight at a time; a new beat is taken only when no
//   result waits or in the cycle the waiting result leaves, never while an
//   update is walking.
//   Reset clears the state map, table valid bits, parameters known, triggers
//   and current/entry; table and condition contents stay undefined until
//   written. When out_o stalls the result is held and in_i is blocked.
// ----------------------------------------------------------------------------
module guarded_transition_state_machine
  import gtsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  gtsm_in_if.sink  in_i,
  gtsm_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  gtsm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.data.command),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  gtsm_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_i.data),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (out_o.data)
  );

endmodule

### tb/gtsm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gtsm_checker
// Watches both channels of the guarded transition state machine, predicts
// every result beat from the accepted command beats and compares in order.
// ----------------------------------------------------------------------------
module gtsm_checker
  import gtsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  in_item_t in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  out_item_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  logic signed [31:0] pval [NumParams];
  logic [NumParams-1:0] pknown;
  logic [NumParams-1:0] trig;
  logic                 ended;
  logic [3:0]           cur;
  logic                 cur_v;
  logic [3:0]           ent;
  logic                 ent_v;
  logic [NumStates-1:0] present;
  logic                 tv [NumTrans];
  logic [4:0]           tfrom [NumTrans];
  logic [3:0]           tto [NumTrans];
  logic [2:0]           tcnt [NumTrans];
  cond_t                conds [NumTrans*NumConds];

  out_item_t expected_q [$];

  assign pending_o = expected_q.size();

  task automatic clear_model();
    pknown = '0; trig = '0; ended = 1'b0;
    cur = '0; cur_v = 1'b0; ent = '0; ent_v = 1'b0; present = '0;
    for (int i = 0; i < NumParams; i++) pval[i] = '0;
    for (int t = 0; t < NumTrans; t++) begin
      tv[t] = 1'b0; tfrom[t] = '0; tto[t] = '0; tcnt[t] = '0;
    end
    for (int c = 0; c < NumTrans*NumConds; c++) conds[c] = '0;
  endtask

  function automatic bit guard_ok(cond_t c);
    case (c.kind)
      COND_ENDED: return ended;
      COND_TRIG:  return trig[c.param];
      COND_EQ:    return pknown[c.param] && pval[c.param] == c.value;
      COND_GT:    return pknown[c.param] && pval[c.param] > c.value;
      COND_LT:    return pknown[c.param] && pval[c.param] < c.value;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic bit row_ok(int t);
    int n;
    n = (tcnt[t] > NumConds) ? NumConds : tcnt[t];
    for (int k = 0; k < n; k++)
      if (!guard_ok(conds[t*NumConds+k])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit enter(logic [3:0] s);
    if (!present[s]) return 1'b0;
    cur = s; cur_v = 1'b1; ended = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit set_entry(logic [3:0] s);
    if (!present[s]) return 1'b0;
    ent = s; ent_v = 1'b1;
    if (!cur_v) return enter(s);
    return 1'b0;
  endfunction

  task automatic drop_state(logic [3:0] s);
    if (!present[s]) return;
    for (int t = 0; t < NumTrans; t++)
      if (tv[t] && (tfrom[t] == {1'b0, s} || tto[t] == s)) tv[t] = 1'b0;
    present[s] = 1'b0;
    if (cur_v && cur == s) begin
      cur = ent_v ? ent : '0;
      cur_v = ent_v;
    end
    if (ent_v && ent == s) begin
      ent = '0; ent_v = 1'b0;
    end
  endtask

  function automatic bit walk_table();
    bit found, entered;
    found = 0; entered = 0;
    if (!cur_v) return 1'b0;
    for (int pass = 0; pass < 2 && !found; pass++)
      for (int t = 0; t < NumTrans && !found; t++) begin
        if (!tv[t]) continue;
        if (pass == 0 ? (tfrom[t] == {1'b0, cur})
                      : (tfrom[t] == AnyState && tto[t] != cur)) begin
          if (row_ok(t)) begin
            found = 1;
            entered = enter(tto[t]);
          end
        end
      end
    ended = 1'b0;
    trig = '0;
    return entered;
  endfunction

  task automatic apply_command(in_item_t b);
    bit st;
    out_item_t r;
    st = 0;
    case (b.command)
      CMD_SET_PARAM: if (b.index < NumParams) begin
        pval[b.index[3:0]] = b.value; pknown[b.index[3:0]] = 1'b1;
      end
      CMD_TRIGGER: if (b.index < NumParams) trig[b.index[3:0]] = 1'b1;
      CMD_ANIM_END: ended = 1'b1;
      CMD_UPDATE: st = walk_table();
      CMD_WRITE_STATE: if (b.index < NumStates) begin
        if (!b.enable) drop_state(b.index[3:0]);
        else if (!present[b.index[3:0]]) begin
          bit was_empty;
          was_empty = (present == '0);
          present[b.index[3:0]] = 1'b1;
          if (was_empty) st = set_entry(b.index[3:0]);
        end
      end
      CMD_WRITE_TRANS: begin
        tv[b.index] = b.enable;
        if (b.enable) begin
          tfrom[b.index] = b.from_state; tto[b.index] = b.to_state;
          tcnt[b.index] = b.cond_count;
        end
      end
      CMD_WRITE_COND: conds[b.index*NumConds + b.cond_slot] =
                        '{kind: b.cond_type, param: b.param_index, value: b.value};
      CMD_SET_ENTRY: st = set_entry(b.to_state);
      CMD_INIT: if (ent_v) st = enter(ent);
      CMD_REMOVE: if (b.index < NumStates) drop_state(b.index[3:0]);
      CMD_CLEAR_ALL: clear_model();
      default: ;
    endcase
    r.current_state = cur_v ? cur : '0;
    r.current_valid = cur_v;
    r.started       = st;
    r.entry_state   = ent_v ? ent : '0;
    r.entry_valid   = ent_v;
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    clear_model();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          if (out_data_i.current_state !== e.current_state)
            report_mismatch("current_state", out_data_i.current_state, e.current_state);
          if (out_data_i.current_valid !== e.current_valid)
            report_mismatch("current_valid", out_data_i.current_valid, e.current_valid);
          if (out_data_i.started !== e.started)
            report_mismatch("started", out_data_i.started, e.started);
          if (out_data_i.entry_state !== e.entry_state)
            report_mismatch("entry_state", out_data_i.entry_state, e.entry_state);
          if (out_data_i.entry_valid !== e.entry_valid)
            report_mismatch("entry_valid", out_data_i.entry_valid, e.entry_valid);
        end
      end
      if (in_valid_i && in_ready_i) apply_command(in_data_i);
    end
  end

endmodule

### tb/guarded_transition_state_machine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// guarded_transition_state_machine_tb
// Drives command beats with random gaps and back-pressure; the checker
// predicts each result beat and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module guarded_transition_state_machine_tb;
  import gtsm_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_recv;
  // conditions written per row, so a walk never reads an unwritten slot
  logic [2:0] cond_written [NumTrans];

  gtsm_in_if  in_ch ();
  gtsm_out_if out_ch ();

  guarded_transition_state_machine DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  gtsm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t rand_item();
    in_item_t b;
    b = '0;
    b.command     = 4'($urandom_range(15));
    b.index       = 5'($urandom);
    b.cond_slot   = 2'($urandom);
    b.from_state  = 5'($urandom_range(16));
    b.to_state    = 4'($urandom);
    b.cond_count  = 3'($urandom);
    b.cond_type   = 3'($urandom);
    b.param_index = 4'($urandom);
    b.value       = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(8)) - 4;
    b.enable      = ($urandom_range(3) != 0);
    return b;
  endfunction

  // keep rows legal: a row's count never exceeds its written conditions unless all four are written
  function automatic in_item_t legalize(in_item_t b);
    if (b.command == CMD_WRITE_TRANS && b.enable) begin
      if (b.cond_count > cond_written[b.index]) b.cond_count = cond_written[b.index];
      if (b.cond_count == cond_written[b.index] && b.cond_count == NumConds &&
          $urandom_range(1))
        b.cond_count = 3'(4 + $urandom_range(3));
    end
    return b;
  endfunction

  task automatic send(in_item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    b = legalize(b);
    if (b.command == CMD_WRITE_COND && cond_written[b.index] == b.cond_slot &&
        cond_written[b.index] < NumConds)
      cond_written[b.index] = 3'(cond_written[b.index] + 1);
    if (b.command == CMD_WRITE_COND && b.cond_slot > cond_written[b.index])
      b.cond_slot = cond_written[b.index] < NumConds ? 2'(cond_written[b.index]) : b.cond_slot;
    if (b.command == CMD_WRITE_COND && cond_written[b.index] <= b.cond_slot)
      cond_written[b.index] = 3'(b.cond_slot + 1);
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic in_item_t cmd(cmd_e c, int idx, int to, logic signed [31:0] v, bit en);
    in_item_t b;
    b = rand_item();
    b.command = c; b.index = 5'(idx); b.to_state = 4'(to); b.value = v; b.enable = en;
    return b;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    in_item_t b;
    for (int i = 0; i < n; i++) begin
      b = rand_item();
      // bias toward a populated machine with frequent updates
      case ($urandom_range(9))
        0, 1, 2: b.command = CMD_UPDATE;
        3: begin b.command = CMD_WRITE_STATE; b.index = 5'($urandom_range(7)); end
        4: begin b.command = CMD_WRITE_COND; b.cond_type = 3'($urandom_range(4)); end
        5: begin
          b.command = CMD_WRITE_TRANS;
          b.from_state = ($urandom_range(3) == 0) ? 5'd16 : 5'($urandom_range(7));
          b.to_state = 4'($urandom_range(7));
        end
        6: begin b.command = 4'($urandom_range(2)); b.index = 5'($urandom_range(15)); end
        7: if (b.command == CMD_CLEAR_ALL && $urandom_range(3) != 0) b.command = CMD_UPDATE;
        default: ;
      endcase
      if (b.command == CMD_CLEAR_ALL)
        for (int t = 0; t < NumTrans; t++) cond_written[t] = '0;
      send(b);
    end
  endtask

  initial begin
    in_item_t b;
    rst_ni = 1'b0;
    hold_recv = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int t = 0; t < NumTrans; t++) cond_written[t] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: states, entry, guards of every kind, edge values
    send(cmd(CMD_UPDATE, 0, 0, 0, 1));
    send(cmd(CMD_WRITE_STATE, 2, 0, 0, 1));
    send(cmd(CMD_WRITE_STATE, 5, 0, 0, 1));
    send(cmd(CMD_WRITE_STATE, 31, 0, 0, 1));
    send(cmd(CMD_SET_PARAM, 0, 0, 32'sh7fffffff, 1));
    send(cmd(CMD_SET_PARAM, 31, 0, 32'sh80000000, 1));
    for (int k = 0; k < 5; k++) begin
      b = cmd(CMD_WRITE_COND, k, 0, (k == 2) ? 32'sh80000000 : 32'sh7fffffff, 1);
      b.cond_slot = 2'd0; b.cond_type = 3'(k); b.param_index = (k == 1) ? 4'd15 : 4'd0;
      send(b);
    end
    b = cmd(CMD_WRITE_COND, 5, 0, 0, 1); b.cond_slot = 2'd0; b.cond_type = 3'd7; send(b);
    for (int k = 0; k < 6; k++) begin
      b = cmd(CMD_WRITE_TRANS, k, 5, 0, 1); b.from_state = (k < 3) ? 5'd2 : 5'd16;
      b.cond_count = 3'd1; send(b);
    end
    send(cmd(CMD_TRIGGER, 0, 0, 0, 1));
    send(cmd(CMD_UPDATE, 0, 0, 0, 1));
    send(cmd(CMD_ANIM_END, 0, 0, 0, 1));
    send(cmd(CMD_SET_ENTRY, 0, 9, 0, 1));
    send(cmd(CMD_INIT, 0, 0, 0, 1));
    send(cmd(CMD_REMOVE, 2, 0, 0, 1));
    send(cmd(CMD_WRITE_STATE, 5, 0, 0, 0));
    send(cmd(cmd_e'(4'd15), 0, 0, 0, 1));
    send(cmd(CMD_CLEAR_ALL, 0, 0, 0, 1));
    for (int t = 0; t < NumTrans; t++) cond_written[t] = '0;

    send_idle_pct = 35; recv_idle_pct = 82;
    random_phase(250);
    // long receiver stall while the sender keeps offering beats
    hold_recv = 1'b1;
    fork
      random_phase(20);
      begin
        repeat (300) @(posedge clk_i);
        hold_recv = 1'b0;
      end
    join
    drain();
    send_idle_pct = 82; recv_idle_pct = 35;
    random_phase(230);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(250);

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
